// ===== design/ita_pkg.sv =====
// Shared constants and types for the integer to decimal ASCII converter.
`timescale 1ns / 1ps
`default_nettype none

package ita_pkg;

    localparam int DEF_VALUE_BITS = 32;

    localparam logic [7:0] CHAR_ZERO  = 8'd48;
    localparam logic [7:0] CHAR_MINUS = 8'd45;

    // Controls shared by every digit cell of the chain
    typedef struct packed {
        logic clear;      // start a new conversion
        logic bit_shift;  // double-dabble step: adjust, then shift one bit in
        logic dig_shift;  // move whole digits one cell toward the top
    } t_cell_ctrl;

endpackage

`default_nettype wire

// ===== design/ita_cell.sv =====
// One BCD digit cell of the double-dabble chain.
`timescale 1ns / 1ps
`default_nettype none

module ita_cell (
    input  wire logic               i_clk,
    input  wire ita_pkg::t_cell_ctrl i_ctrl,
    input  wire logic               i_bit_in,
    input  wire logic [3:0]         i_digit_in,
    output logic                    o_bit_out,
    output logic [3:0]              o_digit
);
    import ita_pkg::*;

    logic [3:0] r_digit;
    logic [3:0] n_digit;
    logic [3:0] w_adj;

    // add 3 when the digit would reach 10 or more after the shift
    assign w_adj     = (r_digit >= 4'd5) ? (r_digit + 4'd3) : r_digit;
    assign o_bit_out = w_adj[3];
    assign o_digit   = r_digit;

    always_comb begin
        n_digit = r_digit;
        if (i_ctrl.clear) begin
            n_digit = 4'd0;
        end else if (i_ctrl.bit_shift) begin
            n_digit = {w_adj[2:0], i_bit_in};
        end else if (i_ctrl.dig_shift) begin
            n_digit = i_digit_in;
        end
    end

    always_ff @(posedge i_clk) begin
        r_digit <= n_digit;
    end

endmodule

`default_nettype wire

// ===== design/int_to_decimal_ascii_core.sv =====
// Top level: signed integer to decimal ASCII text, one character per item.
`timescale 1ns / 1ps
`default_nettype none

// Takes one signed VALUE_BITS-bit number and sends its decimal text one
// character per output item: a '-' for negative values, then the digits most
// significant first without leading zeros; the final character has o_last set.
// Conversion runs through a chain of BCD digit cells (double dabble) that takes
// one magnitude bit per cycle; leading zeros are then dropped at one digit per
// cycle, and characters leave at one per cycle while the output side does not
// stall. The next number is taken once the last character of the current one
// sits in the output register.

module int_to_decimal_ascii_core #(
    parameter int VALUE_BITS = ita_pkg::DEF_VALUE_BITS
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_ready,
    input  wire logic signed [VALUE_BITS-1:0] i_value,
    output logic                              o_valid,
    input  wire logic                         i_ready,
    output logic [7:0]                        o_character,
    output logic                              o_last
);
    import ita_pkg::*;

    // decimal digits of the largest magnitude, 2^(VALUE_BITS-1)
    localparam int DIGITS = ((VALUE_BITS - 1) * 30103) / 100000 + 1;
    localparam int CNT_W  = $clog2(VALUE_BITS + 1);
    localparam int REM_W  = $clog2(DIGITS + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CONV,
        S_SKIP,
        S_SIGN,
        S_EMIT
    } t_state;

    t_state                r_state;
    logic [VALUE_BITS-1:0] r_mag;
    logic                  r_neg;
    logic [CNT_W-1:0]      r_cnt;
    logic [REM_W-1:0]      r_rem;
    logic                  r_o_valid;
    logic [7:0]            r_o_char;
    logic                  r_o_last;

    logic                  w_accept;
    logic                  w_slot_free;
    logic                  w_top_zero;
    logic [VALUE_BITS-1:0] w_raw;
    t_cell_ctrl            w_ctrl;
    logic [3:0]            w_digit [DIGITS];
    logic                  w_carry [DIGITS];

    assign o_ready     = (r_state == S_IDLE);
    assign w_accept    = i_valid && o_ready;
    assign w_slot_free = !r_o_valid || i_ready;
    assign w_top_zero  = (w_digit[DIGITS-1] == 4'd0);
    assign w_raw       = i_value;

    assign o_valid     = r_o_valid;
    assign o_character = r_o_char;
    assign o_last      = r_o_last;

    always_comb begin
        w_ctrl.clear     = w_accept;
        w_ctrl.bit_shift = (r_state == S_CONV);
        w_ctrl.dig_shift = ((r_state == S_SKIP) && w_top_zero && (r_rem > REM_W'(1)))
                        || ((r_state == S_EMIT) && w_slot_free);
    end

    // cell 0 holds the least significant digit
    for (genvar g = 0; g < DIGITS; g++) begin : g_cell
        logic       w_bit_in;
        logic [3:0] w_digit_in;
        if (g == 0) begin : g_first
            assign w_bit_in   = r_mag[VALUE_BITS-1];
            assign w_digit_in = 4'd0;
        end else begin : g_rest
            assign w_bit_in   = w_carry[g-1];
            assign w_digit_in = w_digit[g-1];
        end
        ita_cell u_cell (
            .i_clk      (i_clk),
            .i_ctrl     (w_ctrl),
            .i_bit_in   (w_bit_in),
            .i_digit_in (w_digit_in),
            .o_bit_out  (w_carry[g]),
            .o_digit    (w_digit[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_o_valid <= 1'b0;
        end else begin
            if (w_slot_free) begin
                r_o_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_neg   <= w_raw[VALUE_BITS-1];
                        r_mag   <= w_raw[VALUE_BITS-1] ? (~w_raw + VALUE_BITS'(1)) : w_raw;
                        r_cnt   <= CNT_W'(VALUE_BITS);
                        r_state <= S_CONV;
                    end
                end
                S_CONV: begin
                    r_mag <= {r_mag[VALUE_BITS-2:0], 1'b0};
                    r_cnt <= r_cnt - CNT_W'(1);
                    if (r_cnt == CNT_W'(1)) begin
                        r_rem   <= REM_W'(DIGITS);
                        r_state <= S_SKIP;
                    end
                end
                S_SKIP: begin
                    if (w_top_zero && (r_rem > REM_W'(1))) begin
                        r_rem <= r_rem - REM_W'(1);
                    end else begin
                        r_state <= r_neg ? S_SIGN : S_EMIT;
                    end
                end
                S_SIGN: begin
                    if (w_slot_free) begin
                        r_o_valid <= 1'b1;
                        r_o_char  <= CHAR_MINUS;
                        r_o_last  <= 1'b0;
                        r_state   <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (w_slot_free) begin
                        r_o_valid <= 1'b1;
                        r_o_char  <= CHAR_ZERO + {4'd0, w_digit[DIGITS-1]};
                        r_o_last  <= (r_rem == REM_W'(1));
                        r_rem     <= r_rem - REM_W'(1);
                        if (r_rem == REM_W'(1)) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire
